@@ hw/rtl/pie_pkg.sv @@
// Shared types and constants for the parenthesised infix evaluator.
package pie_pkg;

    localparam logic [2:0] KIND_OPERAND = 3'd0;
    localparam logic [2:0] KIND_OPEN    = 3'd1;
    localparam logic [2:0] KIND_OPER    = 3'd2;
    localparam logic [2:0] KIND_CLOSE   = 3'd3;
    localparam logic [2:0] KIND_END     = 3'd4;

    localparam logic [2:0] OP_ADD  = 3'd0;
    localparam logic [2:0] OP_SUB  = 3'd1;
    localparam logic [2:0] OP_MUL  = 3'd2;
    localparam logic [2:0] OP_DIV  = 3'd3;
    localparam logic [2:0] OP_NEG  = 3'd4;
    localparam logic [2:0] OP_OPEN = 3'd5;

    localparam logic [31:0] MOST_NEG = 32'h8000_0000;
    localparam logic [31:0] MOST_POS = 32'h7FFF_FFFF;

    // commands from controller to datapath
    typedef struct packed {
        logic       take_token;  // latch input item
        logic       vpop_rd;     // read value stack top, decrement count
        logic       vpush;       // push token value
        logic       vpush_res;   // push computed result
        logic       opop_rd;     // read operator stack top, decrement count
        logic       opush;       // push operator code
        logic       opush_open;  // push open mark
        logic       lat_b;       // latch popped value as b
        logic       lat_a;       // latch popped value as a
        logic       lat_op;      // latch popped operator
        logic       compute;     // form result for add/sub/mul/neg
        logic       div_start;   // start divider
        logic       set_err;
        logic       clr_all;
        logic       out_load;
    } pie_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic [2:0] kind;
        logic [2:0] op_code;
        logic       v_empty;
        logic       v_full;
        logic       o_empty;
        logic       o_full;
        logic       err;
        logic       rd_most_neg;
        logic [2:0] rd_op;
        logic [2:0] op;
        logic       div_done;
    } pie_sts_t;

endpackage

@@ hw/rtl/pie_divider.sv @@
// Iterative signed 32-bit divider, one quotient bit per cycle.
module pie_divider
    import pie_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [31:0] quotient
);

    logic [31:0] rem_reg, rem_next;
    logic [31:0] quo_reg, quo_next;
    logic [31:0] den_reg, den_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        neg_reg, neg_next;
    logic        zero_reg, zero_next;
    logic        done_reg, done_next;
    logic [32:0] trial;
    logic [32:0] shifted;

    assign shifted = {rem_reg, quo_reg[31]};
    assign trial   = shifted - {1'b0, den_reg};

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        neg_next  = neg_reg;
        zero_next = zero_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = 32'd0;
            quo_next  = dividend[31] ? (32'd0 - dividend) : dividend;
            den_next  = divisor[31] ? (32'd0 - divisor) : divisor;
            neg_next  = dividend[31] ^ divisor[31];
            zero_next = (divisor == 32'd0);
            cnt_next  = 6'd32;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial[32])
            begin
                rem_next = shifted[31:0];
                quo_next = {quo_reg[30:0], 1'b0};
            end
            else
            begin
                rem_next = trial[31:0];
                quo_next = {quo_reg[30:0], 1'b1};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 6'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        den_reg  <= den_next;
        neg_reg  <= neg_next;
        zero_reg <= zero_next;
    end

    assign done     = done_reg;
    assign quotient = zero_reg ? MOST_POS : (neg_reg ? (32'd0 - quo_reg) : quo_reg);

endmodule

@@ hw/rtl/pie_datapath.sv @@
// Stacks, operand registers, arithmetic and output register.
module pie_datapath
    import pie_pkg::*;
#(
    parameter int STACK_DEPTH = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [2:0]  in_kind,
    input  logic [31:0] in_value,
    input  logic [2:0]  in_op_code,
    input  pie_cmd_t    cmd,
    output pie_sts_t    sts,
    output logic [31:0] result_value,
    output logic        error
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam logic [CW-1:0] FULL = CW'(STACK_DEPTH);

    logic [31:0] vmem [STACK_DEPTH];
    logic [2:0]  omem [STACK_DEPTH];

    logic [CW-1:0] vcnt_reg, vcnt_next;
    logic [CW-1:0] ocnt_reg, ocnt_next;
    logic          err_reg, err_next;
    logic [2:0]    kind_reg, opc_reg, op_reg;
    logic [31:0]   val_reg, a_reg, b_reg, res_reg, vrd_reg;
    logic [2:0]    ord_reg;
    logic [31:0]   out_val_reg;
    logic          out_err_reg;
    logic [31:0]   quotient;
    logic          div_done;
    logic [CW-1:0] vtop, otop;
    logic          fin_bad;

    assign vtop = vcnt_reg - CW'(1);
    assign otop = ocnt_reg - CW'(1);

    pie_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (a_reg),
        .divisor  (b_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    always_comb
    begin
        vcnt_next = vcnt_reg;
        ocnt_next = ocnt_reg;
        err_next  = err_reg;
        if (cmd.vpop_rd)
            vcnt_next = vtop;
        if (cmd.vpush || cmd.vpush_res)
            vcnt_next = vcnt_reg + CW'(1);
        if (cmd.opop_rd)
            ocnt_next = otop;
        if (cmd.opush || cmd.opush_open)
            ocnt_next = ocnt_reg + CW'(1);
        if (cmd.set_err)
            err_next = 1'b1;
        if (cmd.clr_all)
        begin
            vcnt_next = '0;
            ocnt_next = '0;
            err_next  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vcnt_reg <= '0;
            ocnt_reg <= '0;
            err_reg  <= 1'b0;
        end
        else
        begin
            vcnt_reg <= vcnt_next;
            ocnt_reg <= ocnt_next;
            err_reg  <= err_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.vpush)
            vmem[vcnt_reg[AW-1:0]] <= val_reg;
        else if (cmd.vpush_res)
            vmem[vcnt_reg[AW-1:0]] <= res_reg;
        if (cmd.vpop_rd)
            vrd_reg <= vmem[vtop[AW-1:0]];
        if (cmd.opush)
            omem[ocnt_reg[AW-1:0]] <= opc_reg;
        else if (cmd.opush_open)
            omem[ocnt_reg[AW-1:0]] <= OP_OPEN;
        if (cmd.opop_rd)
            ord_reg <= omem[otop[AW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take_token)
        begin
            kind_reg <= in_kind;
            val_reg  <= in_value;
            opc_reg  <= in_op_code;
        end
        if (cmd.lat_b)
            b_reg <= vrd_reg;
        if (cmd.lat_a)
            a_reg <= vrd_reg;
        if (cmd.lat_op)
            op_reg <= ord_reg;
        if (cmd.compute)
        begin
            case (op_reg)
                OP_ADD:  res_reg <= a_reg + b_reg;
                OP_SUB:  res_reg <= a_reg - b_reg;
                OP_MUL:  res_reg <= a_reg * b_reg;
                OP_NEG:  res_reg <= 32'd0 - a_reg;
                default: res_reg <= res_reg;
            endcase
        end
        else if (div_done)
            res_reg <= quotient;
    end

    // an empty value stack at the end token has already raised the error flag
    assign fin_bad = err_reg || vcnt_reg != '0 || vrd_reg == MOST_NEG
                     || ocnt_reg != '0;

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_err_reg <= fin_bad;
            out_val_reg <= fin_bad ? MOST_NEG : vrd_reg;
        end
    end

    assign result_value = out_val_reg;
    assign error        = out_err_reg;

    assign sts.kind        = kind_reg;
    assign sts.op_code     = opc_reg;
    assign sts.v_empty     = (vcnt_reg == '0);
    assign sts.v_full      = (vcnt_reg == FULL);
    assign sts.o_empty     = (ocnt_reg == '0);
    assign sts.o_full      = (ocnt_reg == FULL);
    assign sts.err         = err_reg;
    assign sts.rd_most_neg = (vrd_reg == MOST_NEG);
    assign sts.rd_op       = ord_reg;
    assign sts.op          = op_reg;
    assign sts.div_done    = div_done;

endmodule

@@ hw/rtl/pie_controller.sv @@
// Token sequencer for the two-stack evaluator.
module pie_controller
    import pie_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     s_tvalid,
    output logic     s_tready,
    output logic     m_tvalid,
    input  logic     m_tready,
    output pie_cmd_t cmd,
    input  pie_sts_t sts
);

    typedef enum logic [12:0] {
        ST_IDLE   = 13'b0000000000001,
        ST_DISP   = 13'b0000000000010,
        ST_CPOP   = 13'b0000000000100,
        ST_COP    = 13'b0000000001000,
        ST_B      = 13'b0000000010000,
        ST_BCHK   = 13'b0000000100000,
        ST_ACHK   = 13'b0000001000000,
        ST_CALC   = 13'b0000010000000,
        ST_DIVW   = 13'b0000100000000,
        ST_PUSH   = 13'b0001000000000,
        ST_MCHK   = 13'b0010000000000,
        ST_END    = 13'b0100000000000,
        ST_OUT    = 13'b1000000000000
    } state_t;

    state_t state_reg, state_next;
    logic   ovalid_reg, ovalid_next;

    assign s_tready = (state_reg == ST_IDLE) && !(ovalid_reg && !m_tready);
    assign m_tvalid = ovalid_reg;

    always_comb
    begin
        state_next  = state_reg;
        ovalid_next = ovalid_reg;
        cmd         = '0;
        if (ovalid_reg && m_tready)
            ovalid_next = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid && s_tready)
                begin
                    cmd.take_token = 1'b1;
                    state_next     = ST_DISP;
                end
            end
            ST_DISP:
            begin
                state_next = ST_IDLE;
                if (sts.kind == KIND_END)
                begin
                    if (sts.v_empty)
                        cmd.set_err = 1'b1;
                    else
                        cmd.vpop_rd = 1'b1;
                    state_next = ST_END;
                end
                else if (!sts.err)
                begin
                    case (sts.kind)
                        KIND_OPERAND:
                            if (sts.v_full) cmd.set_err = 1'b1;
                            else cmd.vpush = 1'b1;
                        KIND_OPEN:
                            if (sts.o_full) cmd.set_err = 1'b1;
                            else cmd.opush_open = 1'b1;
                        KIND_OPER:
                            if (sts.op_code > OP_NEG || sts.o_full) cmd.set_err = 1'b1;
                            else cmd.opush = 1'b1;
                        KIND_CLOSE:
                            if (sts.o_empty) cmd.set_err = 1'b1;
                            else
                            begin
                                cmd.opop_rd = 1'b1;
                                state_next  = ST_CPOP;
                            end
                        default: ;
                    endcase
                end
            end
            ST_CPOP:
            begin
                cmd.lat_op = 1'b1;
                if (sts.rd_op > OP_NEG)
                begin
                    cmd.set_err = 1'b1;
                    state_next  = ST_IDLE;
                end
                else if (sts.v_empty)
                begin
                    cmd.set_err = 1'b1;
                    state_next  = ST_IDLE;
                end
                else
                begin
                    cmd.vpop_rd = 1'b1;
                    state_next  = ST_COP;
                end
            end
            ST_COP:
            begin
                // first popped value: operand of negate, or b
                if (sts.rd_most_neg)
                begin
                    cmd.set_err = 1'b1;
                    state_next  = ST_IDLE;
                end
                else if (sts.op == OP_NEG)
                begin
                    cmd.lat_a  = 1'b1;
                    state_next = ST_CALC;
                end
                else
                begin
                    cmd.lat_b  = 1'b1;
                    state_next = ST_B;
                end
            end
            ST_B:
            begin
                if (sts.v_empty)
                begin
                    cmd.set_err = 1'b1;
                    state_next  = ST_IDLE;
                end
                else
                begin
                    cmd.vpop_rd = 1'b1;
                    state_next  = ST_ACHK;
                end
            end
            ST_ACHK:
            begin
                if (sts.rd_most_neg)
                begin
                    cmd.set_err = 1'b1;
                    state_next  = ST_IDLE;
                end
                else
                begin
                    cmd.lat_a  = 1'b1;
                    state_next = ST_BCHK;
                end
            end
            ST_BCHK:
            begin
                if (sts.op == OP_DIV)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIVW;
                end
                else
                begin
                    cmd.compute = 1'b1;
                    state_next  = ST_PUSH;
                end
            end
            ST_CALC:
            begin
                cmd.compute = 1'b1;
                state_next  = ST_PUSH;
            end
            ST_DIVW:
            begin
                if (sts.div_done)
                    state_next = ST_PUSH;
            end
            ST_PUSH:
            begin
                if (sts.v_full)
                begin
                    cmd.set_err = 1'b1;
                    state_next  = ST_IDLE;
                end
                else
                begin
                    cmd.vpush_res = 1'b1;
                    if (sts.o_empty)
                    begin
                        cmd.set_err = 1'b1;
                        state_next  = ST_IDLE;
                    end
                    else
                    begin
                        cmd.opop_rd = 1'b1;
                        state_next  = ST_MCHK;
                    end
                end
            end
            ST_MCHK:
            begin
                if (sts.rd_op != OP_OPEN)
                    cmd.set_err = 1'b1;
                state_next = ST_IDLE;
            end
            ST_END:
            begin
                cmd.out_load = 1'b1;
                cmd.clr_all  = 1'b1;
                state_next   = ST_OUT;
            end
            ST_OUT:
            begin
                if (!ovalid_reg || m_tready)
                begin
                    ovalid_next = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
        end
    end

endmodule

@@ hw/rtl/parenthesized_infix_evaluator_unit.sv @@
// Top level of the parenthesised infix evaluator.
//
// Input stream s_*: one token per item, tdata = {op_code, value, kind} padded
// to 40 bits. Output stream m_*: one item per end token, carrying the final
// value and an error flag.
// Operand, parenthesis and operator tokens finish in the dispatch state; a
// close parenthesis pops, checks and computes, waiting on the divider for a
// division; an end token pops the final value, then loads the output register.
// One token is in work at a time; the next is taken once the sequencer is
// back in its idle state.
// Reset empties both stacks, clears the sticky error and drops any pending
// result. Stack contents are not cleared.
// While the receiver stalls, the result is held in the output register and
// no further token is taken until that result is accepted.
module parenthesized_infix_evaluator_unit
    import pie_pkg::*;
#(
    parameter int STACK_DEPTH = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // kind[2:0], value[34:3], op_code[37:35], zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // result_value[31:0], error[32], zero pad
);

    pie_cmd_t    cmd;
    pie_sts_t    sts;
    logic [31:0] result_value;
    logic        error;

    pie_controller u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    pie_datapath #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_kind      (s_tdata[2:0]),
        .in_value     (s_tdata[34:3]),
        .in_op_code   (s_tdata[37:35]),
        .cmd          (cmd),
        .sts          (sts),
        .result_value (result_value),
        .error        (error)
    );

    assign m_tdata = {7'd0, error, result_value};

endmodule

@@ tb/sv/parenthesized_infix_evaluator_unit_tb.sv @@
// Testbench for the infix evaluator: token streams against an in-bench evaluator model.
`timescale 1ns / 100ps

module parenthesized_infix_evaluator_unit_tb;
    import pie_pkg::*;

    localparam int DEPTH = 64;
    localparam int CYCLE_LIMIT = 1500000;

    typedef struct packed {
        logic [31:0] value;
        logic        error;
    } eval_result_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;

    logic [31:0] val_stk [DEPTH];
    logic [2:0]  opr_stk [DEPTH];
    int          val_cnt;
    int          opr_cnt;
    bit          err_flag;

    eval_result_t expected_results[$];
    int  fail_count;
    int  cycle_count;
    int  send_idle_pct;
    int  recv_idle_pct;
    int  hold_cycles;

    parenthesized_infix_evaluator_unit #(.STACK_DEPTH(DEPTH)) u_top (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    function automatic logic [31:0] eval_binary(logic [2:0] op, logic [31:0] a, logic [31:0] b);
        longint qa;
        longint qb;
        qa = longint'(signed'(a));
        qb = longint'(signed'(b));
        case (op)
            OP_ADD:  return a + b;
            OP_SUB:  return a - b;
            OP_MUL:  return a * b;
            default: return (b == 32'd0) ? MOST_POS : 32'(qa / qb);
        endcase
    endfunction

    function automatic bit take_value(output logic [31:0] v);
        v = '0;
        if (val_cnt == 0)
        begin
            err_flag = 1'b1;
            return 1'b0;
        end
        val_cnt--;
        v = val_stk[val_cnt];
        if (v == MOST_NEG)
        begin
            err_flag = 1'b1;
            return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic void put_value(logic [31:0] v);
        if (val_cnt >= DEPTH)
            err_flag = 1'b1;
        else
        begin
            val_stk[val_cnt] = v;
            val_cnt++;
        end
    endfunction

    function automatic void put_operator(logic [2:0] c);
        if (opr_cnt >= DEPTH)
            err_flag = 1'b1;
        else
        begin
            opr_stk[opr_cnt] = c;
            opr_cnt++;
        end
    endfunction

    function automatic void reduce_group();
        logic [2:0]  op;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] r;
        if (opr_cnt == 0)
        begin
            err_flag = 1'b1;
            return;
        end
        opr_cnt--;
        op = opr_stk[opr_cnt];
        if (op == OP_OPEN)
        begin
            err_flag = 1'b1;
            return;
        end
        if (op == OP_NEG)
        begin
            if (!take_value(a))
                return;
            r = 32'd0 - a;
        end
        else if (op < OP_NEG)
        begin
            if (!take_value(b))
                return;
            if (!take_value(a))
                return;
            r = eval_binary(op, a, b);
        end
        else
        begin
            err_flag = 1'b1;
            return;
        end
        put_value(r);
        if (err_flag)
            return;
        if (opr_cnt == 0)
        begin
            err_flag = 1'b1;
            return;
        end
        opr_cnt--;
        if (opr_stk[opr_cnt] != OP_OPEN)
            err_flag = 1'b1;
    endfunction

    function automatic void evaluate_token(logic [2:0] kind, logic [31:0] value, logic [2:0] op);
        eval_result_t res;
        logic [31:0]  fin;
        bit           bad;
        if (kind == KIND_END)
        begin
            fin = '0;
            bad = err_flag;
            if (val_cnt == 0)
                bad = 1'b1;
            else
            begin
                val_cnt--;
                fin = val_stk[val_cnt];
            end
            if (fin == MOST_NEG || val_cnt != 0 || opr_cnt != 0)
                bad = 1'b1;
            res.value = bad ? MOST_NEG : fin;
            res.error = bad;
            expected_results.push_back(res);
            val_cnt  = 0;
            opr_cnt  = 0;
            err_flag = 1'b0;
            return;
        end
        if (err_flag)
            return;
        case (kind)
            KIND_OPERAND: put_value(value);
            KIND_OPEN:    put_operator(OP_OPEN);
            KIND_OPER:
                if (op > OP_NEG)
                    err_flag = 1'b1;
                else
                    put_operator(op);
            KIND_CLOSE:   reduce_group();
            default:      ;
        endcase
    endfunction

    task automatic send_token(logic [2:0] kind, logic [31:0] value = '0, logic [2:0] op = '0);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, op, value, kind};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        evaluate_token(kind, value, op);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (60)
            @(posedge clk);
    endtask

    function automatic logic [31:0] rand_operand();
        case ($urandom_range(5))
            0:       return 32'($urandom_range(9));
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h8000_0001 + 32'($urandom_range(3));
            3:       return -32'($urandom_range(20));
            default: return $urandom();
        endcase
    endfunction

    // emit a well-formed expression, depth-bounded
    task automatic send_expr(int lvl);
        logic [2:0] op;
        if (lvl == 0 || $urandom_range(2) == 0)
        begin
            send_token(KIND_OPERAND, rand_operand());
            return;
        end
        op = 3'($urandom_range(4));
        send_token(KIND_OPEN);
        if (op == OP_NEG)
        begin
            send_token(KIND_OPER, '0, op);
            send_expr(lvl - 1);
        end
        else
        begin
            send_expr(lvl - 1);
            send_token(KIND_OPER, '0, op);
            send_expr(lvl - 1);
        end
        send_token(KIND_CLOSE);
    endtask

    task automatic send_noise();
        send_token(3'($urandom_range(7)), $urandom(), 3'($urandom_range(7)));
    endtask

    task automatic test_directed();
        send_token(KIND_OPERAND, 32'h7FFF_FFFF);
        send_token(KIND_END);
        send_token(KIND_END);
        send_token(KIND_OPERAND, MOST_NEG);
        send_token(KIND_END);
        for (int c = 0; c <= 4; c++)
        begin
            send_token(KIND_OPEN);
            if (c == OP_NEG)
                send_token(KIND_OPER, '0, 3'(c));
            else
                send_token(KIND_OPERAND, 32'hFFFF_FFF9);
            if (c != OP_NEG)
                send_token(KIND_OPER, '0, 3'(c));
            send_token(KIND_OPERAND, (c == OP_DIV) ? 32'd0 : 32'd2);
            send_token(KIND_CLOSE);
            send_token(KIND_END);
        end
        send_token(KIND_OPEN);
        send_token(KIND_CLOSE);
        send_token(KIND_END);
        send_token(KIND_OPERAND, 32'd3);
        send_token(KIND_OPER, '0, 3'd7);
        send_token(3'd6, 32'hFFFF_FFFF, 3'd7);
        send_token(KIND_END);
        send_token(KIND_CLOSE);
        send_token(KIND_END);
        send_token(KIND_OPERAND, 32'd1);
        send_token(KIND_OPERAND, 32'd2);
        send_token(KIND_OPER, '0, OP_ADD);
        send_token(KIND_CLOSE);
        send_token(KIND_END);
        wait_drained();
    endtask

    task automatic test_overflow();
        for (int i = 0; i < DEPTH + 2; i++)
            send_token(KIND_OPERAND, 32'(i));
        send_token(KIND_END);
        for (int i = 0; i < DEPTH + 2; i++)
            send_token(KIND_OPEN);
        send_token(KIND_END);
        wait_drained();
    endtask

    task automatic test_random(int items);
        int sent;
        sent = 0;
        while (sent < items)
        begin
            case ($urandom_range(9))
                0:       send_noise();
                1:
                begin
                    send_expr(2);
                    send_noise();
                end
                default: send_expr(3);
            endcase
            send_token(KIND_END);
            sent += 12;
        end
        wait_drained();
    endtask

    task automatic test_backpressure();
        hold_cycles = 400;
        for (int i = 0; i < 6; i++)
        begin
            send_expr(2);
            send_token(KIND_END);
        end
        wait_drained();
    endtask

    always @(posedge clk)
    begin
        if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= !(recv_idle_pct > 0 && $urandom_range(99) < recv_idle_pct);
    end

    always @(posedge clk)
    begin
        eval_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: result with none expected, actual %h", $time, m_tdata[32:0]);
                fail_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (m_tdata[31:0] !== want.value || m_tdata[32] !== want.error)
                begin
                    $display("%0t: mismatch expected value %h error %b, actual value %h error %b",
                             $time, want.value, want.error, m_tdata[31:0], m_tdata[32]);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("parenthesized_infix_evaluator_unit regression: fail");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        val_cnt = 0;
        opr_cnt = 0;
        err_flag = 1'b0;
        fail_count = 0;
        cycle_count = 0;
        hold_cycles = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (6)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_overflow();
        send_idle_pct = 34;
        recv_idle_pct = 88;
        test_random(600);
        send_idle_pct = 88;
        recv_idle_pct = 34;
        test_random(600);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_backpressure();
        test_random(600);
        if (fail_count == 0)
            $display("parenthesized_infix_evaluator_unit regression: pass");
        else
            $display("parenthesized_infix_evaluator_unit regression: fail");
        $finish;
    end

endmodule
